### rtl/touch_grid_step_sequencer_macros.svh
// Assertion macros shared by the touch grid step sequencer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TOUCH_GRID_STEP_SEQUENCER_MACROS_SVH
`define TOUCH_GRID_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tgs_pkg.sv
// Shared types and constants of the touch grid step sequencer.
// No dependencies; imported by every module of the block but tgs_ram.
package tgs_pkg;

  localparam int STEPS_DEF  = 8;
  localparam int VOICES_DEF = 8;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W    = 32;
  localparam int DIST_W    = 16;
  localparam int CELL_AW   = 7;
  localparam int CELLS     = 128;
  localparam int MASK_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD_MS = 2'd3;

  localparam logic [CFG_W-1:0] ZONE_THRESHOLD_RST = 16'd300;
  localparam logic [CFG_W-1:0] MIN_DISTANCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LOCKOUT_MS_RST     = 16'd150;
  localparam logic [CFG_W-1:0] STEP_PERIOD_MS_RST = 16'd180;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RESET  = 2'd3
  } tgs_op_e;

  // Decisions taken for the item in the input register.
  typedef struct packed {
    logic sample;
    logic touched;
    logic toggle;
    logic fire;
    logic clr_grid;
    logic clr_all;
  } tgs_act_t;

endpackage

### rtl/tgs_ram.sv
// Single-port-write, single-port-read memory with registered, write-first read.
// Depends on nothing; used for the pattern rows and the per-cell toggle times.
module tgs_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Forward a same-edge write so a following item sees its own predecessor.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tgs_eval.sv
// Per-item evaluation: touch window, lockout, tempo check and grid row update.
// Depends on tgs_pkg.
module tgs_eval
  import tgs_pkg::*;
#(
  parameter int STEPS  = STEPS_DEF,
  parameter int VOICES = VOICES_DEF
) (
  input  logic [1:0]                                   op_i,
  input  logic                                         hand_i,
  input  logic [2:0]                                   row_i,
  input  logic [2:0]                                   col_i,
  input  logic [DIST_W-1:0]                            distance_i,
  input  logic [TIME_W-1:0]                            now_ms_i,
  input  logic [CFG_W-1:0]                             zone_threshold_i,
  input  logic [CFG_W-1:0]                             min_distance_i,
  input  logic [CFG_W-1:0]                             lockout_ms_i,
  input  logic [CFG_W-1:0]                             step_period_ms_i,
  input  logic                                         touch_was_i,
  input  logic [TIME_W-1:0]                            last_toggle_i,
  input  logic [TIME_W-1:0]                            last_step_i,
  input  logic [2*((VOICES < MASK_W) ? VOICES : MASK_W)-1:0] word_i,
  output tgs_act_t                                     act_o,
  output logic [2*((VOICES < MASK_W) ? VOICES : MASK_W)-1:0] word_o
);

  localparam int GW = (VOICES < MASK_W) ? VOICES : MASK_W;
  localparam bit COL_ALL = (STEPS >= 8);
  localparam bit ROW_ALL = (VOICES >= 8);

  tgs_op_e           op;
  logic              touched;
  logic              col_ok;
  logic              row_ok;
  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] elapsed;
  logic [GW-1:0]     bit_m;

  always_comb begin
    op      = tgs_op_e'(op_i);
    touched = (distance_i < zone_threshold_i) && (distance_i > min_distance_i);
    col_ok  = COL_ALL || (col_i < 3'(STEPS));
    row_ok  = ROW_ALL || (row_i < 3'(VOICES));
    since   = now_ms_i - last_toggle_i;
    elapsed = now_ms_i - last_step_i;
    bit_m   = GW'(1) << row_i;

    act_o.sample   = (op == OP_SAMPLE);
    act_o.touched  = touched;
    act_o.toggle   = (op == OP_SAMPLE) && touched && !touch_was_i
                     && (since > TIME_W'(lockout_ms_i)) && col_ok && row_ok;
    act_o.fire     = (op == OP_TICK) && (elapsed >= TIME_W'(step_period_ms_i));
    act_o.clr_grid = (op == OP_CLEAR) || (op == OP_RESET);
    act_o.clr_all  = (op == OP_RESET);

    // Left hand edits the melody half, right hand the drum half.
    if (hand_i) begin
      word_o = word_i ^ {bit_m, GW'(0)};
    end else begin
      word_o = word_i ^ {GW'(0), bit_m};
    end
  end

endmodule

### rtl/touch_grid_step_sequencer.sv
// Top level of the touch grid step sequencer: input register, state, result register.
// Depends on tgs_pkg, tgs_ram, tgs_eval and touch_grid_step_sequencer_macros.svh.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_stall_o  op, hand, row, col, distance, now_ms
//   out       source     out_valid_o / out_stall_i played_step, melody_mask, drum_mask
//   cfg       sink       cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a tick that steps loads its result when it leaves the input register.
// The rate is set by one read-modify-write of the pattern memory and the cell memory
// (touch flag and toggle time) per item, read at accept and written back when the item
// leaves the input register.
// Reset is asynchronous and active low; no clearing pass follows.
// in_stall_o rises only when a stepping tick waits on a stalled, full result register.
module touch_grid_step_sequencer
  import tgs_pkg::*;
#(
  parameter int STEPS  = STEPS_DEF,
  parameter int VOICES = VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic                 hand_i,
  input  logic [2:0]           row_i,
  input  logic [2:0]           col_i,
  input  logic [DIST_W-1:0]    distance_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           played_step_o,
  output logic [MASK_W-1:0]    melody_mask_o,
  output logic [MASK_W-1:0]    drum_mask_o
);

  `include "touch_grid_step_sequencer_macros.svh"

  localparam int GW = (VOICES < MASK_W) ? VOICES : MASK_W;
  localparam int WW = 2 * GW;
  localparam int AW = $clog2(STEPS);
  localparam int XW = (AW > 3) ? AW : 3;

  // Configuration
  logic [CFG_W-1:0] zone_q, min_q, lockout_q, period_q;

  // Input register
  logic              s1_vld_q, s1_vld_d;
  logic [1:0]        s1_op_q;
  logic              s1_hand_q;
  logic [2:0]        s1_row_q, s1_col_q;
  logic [DIST_W-1:0] s1_dist_q;
  logic [TIME_W-1:0] s1_now_q;
  logic [AW-1:0]     s1_gaddr_q;

  // Sequencer state
  logic [AW-1:0]     ph_q, ph_d, ph_next;
  logic [TIME_W-1:0] last_step_q;
  logic [STEPS-1:0]  grid_vld_q;
  logic [CELLS-1:0]  ltt_vld_q;

  // Result register
  logic              out_vld_q;
  logic [2:0]        out_step_q;
  logic [MASK_W-1:0] out_mel_q, out_drum_q;

  logic              in_acc, adv;
  logic [XW-1:0]     col_x, ph_x;
  logic [AW-1:0]     in_col_addr, in_gaddr;
  logic [CELL_AW-1:0] in_cell, s1_cell;
  logic [WW-1:0]     grid_rd, grid_word, grid_new;
  logic [TIME_W:0]   ltt_rd, ltt_wdata;
  logic [TIME_W-1:0] ltt_val;
  logic              touch_was;
  tgs_act_t          act;

  assign in_cell = {hand_i, row_i, col_i};
  assign s1_cell = {s1_hand_q, s1_row_q, s1_col_q};

  always_comb begin
    col_x       = XW'(col_i);
    in_col_addr = col_x[AW-1:0];
    ph_x        = XW'(ph_q);
  end

  assign adv        = s1_vld_q && (!act.fire || !out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    ph_next = (ph_q == AW'(STEPS - 1)) ? '0 : ph_q + AW'(1);
    ph_d    = ph_q;
    if (adv && act.clr_grid) begin
      ph_d = '0;
    end else if (adv && act.fire) begin
      ph_d = ph_next;
    end
    // A tick reads the row the playhead will point at once the current item leaves.
    in_gaddr = (tgs_op_e'(op_i) == OP_TICK) ? ph_d : in_col_addr;
  end

  assign grid_word = grid_vld_q[s1_gaddr_q] ? grid_rd : '0;

  // Cell word: touch flag on top, last toggle time below; unwritten cells read as zero.
  assign ltt_val   = ltt_vld_q[s1_cell] ? ltt_rd[TIME_W-1:0] : '0;
  assign touch_was = ltt_vld_q[s1_cell] && ltt_rd[TIME_W];
  assign ltt_wdata = {act.touched, act.toggle ? s1_now_q : ltt_val};

  tgs_ram #(
    .DEPTH(STEPS),
    .WIDTH(WW)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (adv && act.toggle),
    .waddr_i(s1_gaddr_q),
    .wdata_i(grid_new),
    .re_i   (in_acc),
    .raddr_i(in_gaddr),
    .rdata_o(grid_rd)
  );

  tgs_ram #(
    .DEPTH(CELLS),
    .WIDTH(TIME_W + 1)
  ) u_ltt_ram (
    .clk_i  (clk_i),
    .we_i   (adv && act.sample),
    .waddr_i(s1_cell),
    .wdata_i(ltt_wdata),
    .re_i   (in_acc),
    .raddr_i(in_cell),
    .rdata_o(ltt_rd)
  );

  tgs_eval #(
    .STEPS (STEPS),
    .VOICES(VOICES)
  ) u_eval (
    .op_i            (s1_op_q),
    .hand_i          (s1_hand_q),
    .row_i           (s1_row_q),
    .col_i           (s1_col_q),
    .distance_i      (s1_dist_q),
    .now_ms_i        (s1_now_q),
    .zone_threshold_i(zone_q),
    .min_distance_i  (min_q),
    .lockout_ms_i    (lockout_q),
    .step_period_ms_i(period_q),
    .touch_was_i     (touch_was),
    .last_toggle_i   (ltt_val),
    .last_step_i     (last_step_q),
    .word_i          (grid_word),
    .act_o           (act),
    .word_o          (grid_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q    <= ZONE_THRESHOLD_RST;
      min_q     <= MIN_DISTANCE_RST;
      lockout_q <= LOCKOUT_MS_RST;
      period_q  <= STEP_PERIOD_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZONE_THRESHOLD: zone_q    <= cfg_data_i;
        CFG_MIN_DISTANCE:   min_q     <= cfg_data_i;
        CFG_LOCKOUT_MS:     lockout_q <= cfg_data_i;
        CFG_STEP_PERIOD_MS: period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= op_i;
      s1_hand_q  <= hand_i;
      s1_row_q   <= row_i;
      s1_col_q   <= col_i;
      s1_dist_q  <= distance_i;
      s1_now_q   <= now_ms_i;
      s1_gaddr_q <= in_gaddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= '0;
      last_step_q <= '0;
      grid_vld_q  <= '0;
      ltt_vld_q   <= '0;
    end else begin
      ph_q <= ph_d;
      if (adv) begin
        if (act.clr_grid) begin
          grid_vld_q <= '0;
        end else if (act.toggle) begin
          grid_vld_q[s1_gaddr_q] <= 1'b1;
        end
        if (act.clr_all) begin
          ltt_vld_q   <= '0;
          last_step_q <= '0;
        end else begin
          if (act.sample) begin
            ltt_vld_q[s1_cell] <= 1'b1;
          end
          if (act.fire) begin
            last_step_q <= s1_now_q;
          end
        end
      end
    end
  end

  // Result register: load on a stepping tick, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && act.fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && act.fire) begin
      out_step_q <= ph_x[2:0];
      out_mel_q  <= MASK_W'(grid_word[GW-1:0]);
      out_drum_q <= MASK_W'(grid_word[WW-1:GW]);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign played_step_o = out_step_q;
  assign melody_mask_o = out_mel_q;
  assign drum_mask_o   = out_drum_q;

  `TGS_ASSERT_IMP(a_stall_needs_item, in_stall_o, s1_vld_q, "stall without a held item")
  `TGS_ASSERT_NXT(a_clear_empties_grid, adv && act.clr_grid, grid_vld_q == '0,
                  "grid rows still valid after clear")
  `TGS_ASSERT_NXT(a_reset_clears_cells, adv && act.clr_all,
                  (ltt_vld_q == '0) && (ph_q == '0),
                  "cell state survived a full reset item")
  `TGS_ASSERT_IMP(a_result_from_tick, out_valid_o && !$past(out_valid_o),
                  $past(tgs_op_e'(s1_op_q) == OP_TICK) && $past(adv),
                  "result appeared without a stepping tick")

endmodule

### verif/tb_touch_grid_step_sequencer.sv
`timescale 1ns / 100ps
// Testbench for touch_grid_step_sequencer: directed and random samples, ticks, clears and resets
// across several register settings and idling patterns, checked against a scoreboard predictor.
// Depends on tgs_pkg and the touch_grid_step_sequencer RTL.
module tb_touch_grid_step_sequencer;
  import tgs_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int BLOCK_ITEMS  = 80;
  localparam int BLOCKS       = 16;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [2:0]        step;
    logic [MASK_W-1:0] melody;
    logic [MASK_W-1:0] drums;
  } step_out_t;

  class step_scoreboard;
    logic [CFG_W-1:0]  zone;
    logic [CFG_W-1:0]  min_dist;
    logic [CFG_W-1:0]  lockout;
    logic [CFG_W-1:0]  period;
    logic [MASK_W-1:0] melody_grid [8];
    logic [MASK_W-1:0] drum_grid [8];
    bit                touch_flag [CELLS];
    logic [TIME_W-1:0] toggle_time [CELLS];
    logic [2:0]        playhead;
    logic [TIME_W-1:0] step_time;
    step_out_t         pending [$];
    int                errors;
    int                steps_played;
    int                toggles;

    function new();
      zone     = ZONE_THRESHOLD_RST;
      min_dist = MIN_DISTANCE_RST;
      lockout  = LOCKOUT_MS_RST;
      period   = STEP_PERIOD_MS_RST;
      errors = 0;
      steps_played = 0;
      toggles = 0;
      clear_all();
    endfunction

    function void clear_grids();
      for (int i = 0; i < 8; i++) begin
        melody_grid[i] = '0;
        drum_grid[i]   = '0;
      end
      playhead = '0;
    endfunction

    function void clear_all();
      clear_grids();
      for (int i = 0; i < CELLS; i++) begin
        touch_flag[i]  = 1'b0;
        toggle_time[i] = '0;
      end
      step_time = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ZONE_THRESHOLD: zone = val;
        CFG_MIN_DISTANCE:   min_dist = val;
        CFG_LOCKOUT_MS:     lockout = val;
        CFG_STEP_PERIOD_MS: period = val;
        default: ;
      endcase
    endfunction

    function void note_item(tgs_op_e op, logic hand, logic [2:0] row, logic [2:0] col,
                            logic [DIST_W-1:0] distance, logic [TIME_W-1:0] now);
      logic [CELL_AW-1:0] cell_idx;
      bit                 hit;
      logic [TIME_W-1:0]  since;
      logic [TIME_W-1:0]  elapsed;
      step_out_t          r;
      cell_idx = {hand, row, col};
      case (op)
        OP_SAMPLE: begin
          hit   = (distance < zone) && (distance > min_dist);
          since = now - toggle_time[cell_idx];
          if (hit && !touch_flag[cell_idx] && since > {16'd0, lockout}) begin
            if (hand) drum_grid[col][row] = ~drum_grid[col][row];
            else melody_grid[col][row] = ~melody_grid[col][row];
            toggle_time[cell_idx] = now;
            toggles++;
          end
          touch_flag[cell_idx] = hit;
        end
        OP_TICK: begin
          elapsed = now - step_time;
          if (elapsed >= {16'd0, period}) begin
            step_time = now;
            r.step   = playhead;
            r.melody = melody_grid[playhead];
            r.drums  = drum_grid[playhead];
            pending.push_back(r);
            playhead = playhead + 3'd1;
          end
        end
        OP_CLEAR: clear_grids();
        default:  clear_all();
      endcase
    endfunction

    function void check_result(logic [2:0] step, logic [MASK_W-1:0] melody,
                               logic [MASK_W-1:0] drums);
      step_out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result step %0d melody %h drums %h",
                 $time, step, melody, drums);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      steps_played++;
      if (step !== exp_r.step) begin
        $display("%0t: played_step expected %0d actual %0d", $time, exp_r.step, step);
        errors++;
      end
      if (melody !== exp_r.melody) begin
        $display("%0t: melody_mask expected %h actual %h", $time, exp_r.melody, melody);
        errors++;
      end
      if (drums !== exp_r.drums) begin
        $display("%0t: drum_mask expected %h actual %h", $time, exp_r.drums, drums);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           op_i;
  logic                 hand_i;
  logic [2:0]           row_i;
  logic [2:0]           col_i;
  logic [DIST_W-1:0]    distance_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [2:0]           played_step_o;
  logic [MASK_W-1:0]    melody_mask_o;
  logic [MASK_W-1:0]    drum_mask_o;

  step_scoreboard    sb;
  int                idle_pct;
  int                stall_pct;
  int                items_sent;
  int                cycles;
  int                settings_run;
  logic [TIME_W-1:0] clock_ms;

  touch_grid_step_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .hand_i        (hand_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .distance_i    (distance_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .played_step_o (played_step_o),
    .melody_mask_o (melody_mask_o),
    .drum_mask_o   (drum_mask_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("** touch_grid_step_sequencer: FAILED **");
      $finish;
    end
  end

  // Result side: random stall, check every accepted result.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(played_step_o, melody_mask_o, drum_mask_o);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(tgs_op_e op, logic hand, logic [2:0] row, logic [2:0] col,
                           logic [DIST_W-1:0] distance, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    hand_i     <= hand;
    row_i      <= row;
    col_i      <= col;
    distance_i <= distance;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, hand, row, col, distance, now);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drain all results and let in-flight samples retire before touching registers.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] zone, logic [CFG_W-1:0] min_d,
                               logic [CFG_W-1:0] lock, logic [CFG_W-1:0] per);
    logic [CFG_W-1:0] vals [4];
    vals[0] = zone;
    vals[1] = min_d;
    vals[2] = lock;
    vals[3] = per;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(negedge clk_i);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [DIST_W-1:0] touch_dist();
    if ({1'b0, sb.min_dist} + 17'd1 < {1'b0, sb.zone})
      return DIST_W'($urandom_range(sb.zone - 1, sb.min_dist + 1));
    return DIST_W'($urandom);
  endfunction

  function automatic logic [DIST_W-1:0] release_dist();
    if ($urandom_range(1)) return DIST_W'($urandom_range(sb.min_dist, 0));
    return DIST_W'($urandom_range(65535, sb.zone));
  endfunction

  // Move time forward on the scale of the current lockout and tempo; jump now and then.
  function automatic logic [TIME_W-1:0] advance_clock();
    logic [TIME_W-1:0] span;
    int                r;
    span = (sb.lockout > sb.period) ? sb.lockout : sb.period;
    r = $urandom_range(99);
    if (r < 60) clock_ms = clock_ms + $urandom_range(span / 3 + 2, 0);
    else if (r < 92) clock_ms = clock_ms + $urandom_range(span * 2 + 4, span / 2);
    else if (r < 97) clock_ms = clock_ms + $urandom;
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  task automatic run_block(int n);
    int         i;
    int         r;
    int         len;
    logic       hand;
    logic [2:0] row;
    logic [2:0] col;
    i = 0;
    while (i < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(tgs_op_e'($urandom_range(3)), 1'($urandom), 3'($urandom), 3'($urandom),
                  DIST_W'($urandom), $urandom_range(1) ? $urandom : advance_clock());
        i++;
      end else if (r < 32) begin
        send_item(OP_TICK, 1'($urandom), 3'($urandom), 3'($urandom), DIST_W'($urandom),
                  advance_clock());
        i++;
      end else if (r < 35) begin
        send_item(OP_CLEAR, 1'($urandom), 3'($urandom), 3'($urandom), DIST_W'($urandom),
                  advance_clock());
        i++;
      end else if (r < 37) begin
        send_item(OP_RESET, 1'($urandom), 3'($urandom), 3'($urandom), DIST_W'($urandom),
                  advance_clock());
        i++;
      end else begin
        // Press and release one cell; favor a few cells so flags and lockouts interact.
        hand = 1'($urandom);
        if ($urandom_range(1)) begin
          row = 3'($urandom_range(1));
          col = 3'($urandom_range(1));
        end else begin
          row = 3'($urandom);
          col = 3'($urandom);
        end
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) begin
          send_item(OP_SAMPLE, hand, row, col, (k % 2 == 0) ? touch_dist() : release_dist(),
                    advance_clock());
          i++;
        end
      end
    end
  endtask

  task automatic pick_setting(int s);
    logic [CFG_W-1:0] z;
    case (s)
      0: apply_setting(ZONE_THRESHOLD_RST, MIN_DISTANCE_RST, LOCKOUT_MS_RST,
                       STEP_PERIOD_MS_RST);
      1: apply_setting(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      2: apply_setting(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      3: apply_setting(16'hFFFF, 16'hFFFD, 16'hFFFF, 16'h0001);
      4: apply_setting(16'd1200, 16'd400, 16'd25, 16'd1);
      default: begin
        z = CFG_W'($urandom);
        apply_setting(z, CFG_W'($urandom_range(z, 0)), CFG_W'($urandom_range(2000, 0)),
                      CFG_W'($urandom_range(2000, 1)));
      end
    endcase
  endtask

  initial begin
    sb = new();
    idle_pct     = 0;
    stall_pct    = 0;
    items_sent   = 0;
    cycles       = 0;
    settings_run = 0;
    clock_ms     = '0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_SAMPLE;
    hand_i      = 1'b0;
    row_i       = '0;
    col_i       = '0;
    distance_i  = '0;
    now_ms_i    = '0;
    out_stall_i = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: boundaries of the touch window, lockout, tempo, time wrap, clear and reset.
    send_item(OP_RESET,  1'b0, 3'd0, 3'd0, 16'd0,     32'd0);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd100);
    send_item(OP_SAMPLE, 1'b0, 3'd0, 3'd0, 16'd51,    32'd151);
    send_item(OP_SAMPLE, 1'b0, 3'd0, 3'd0, 16'd50,    32'd160);
    send_item(OP_SAMPLE, 1'b0, 3'd0, 3'd0, 16'd299,   32'd200);
    send_item(OP_SAMPLE, 1'b0, 3'd0, 3'd0, 16'd300,   32'd400);
    send_item(OP_SAMPLE, 1'b0, 3'd0, 3'd0, 16'd120,   32'd500);
    send_item(OP_SAMPLE, 1'b0, 3'd7, 3'd0, 16'd200,   32'd500);
    send_item(OP_SAMPLE, 1'b1, 3'd7, 3'd7, 16'hFFFF,  32'd600);
    send_item(OP_SAMPLE, 1'b1, 3'd7, 3'd7, 16'd250,   32'd600);
    send_item(OP_SAMPLE, 1'b1, 3'd3, 3'd0, 16'd100,   32'd600);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd180);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd359);
    send_item(OP_TICK,   1'b1, 3'd7, 3'd7, 16'hFFFF,  32'd360);
    send_item(OP_CLEAR,  1'b0, 3'd0, 3'd0, 16'd0,     32'd0);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'hFFFF_FFFF);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd179);
    send_item(OP_SAMPLE, 1'b1, 3'd5, 3'd6, 16'd0,     32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 1'b1, 3'd5, 3'd6, 16'd290,   32'hFFFF_FFFF);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd2000);
    send_item(OP_RESET,  1'b1, 3'd7, 3'd7, 16'hFFFF,  32'h5555_AAAA);
    send_item(OP_SAMPLE, 1'b0, 3'd2, 3'd5, 16'd77,    32'h8000_0000);
    send_item(OP_TICK,   1'b0, 3'd0, 3'd0, 16'd0,     32'd180);

    for (int b = 0; b < BLOCKS; b++) begin
      if (b % 2 == 0) pick_setting(b / 2);
      case (b % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      run_block(BLOCK_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d items under %0d register settings and four idling patterns",
             items_sent, settings_run);
    $display("checked %0d played steps; %0d cell toggles predicted", sb.steps_played,
             sb.toggles);
    if (sb.errors == 0) begin
      $display("** touch_grid_step_sequencer: PASSED **");
    end else begin
      $display("** touch_grid_step_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

### touch_grid_step_sequencer.f
+incdir+rtl
rtl/tgs_pkg.sv
rtl/tgs_ram.sv
rtl/tgs_eval.sv
rtl/touch_grid_step_sequencer.sv
verif/tb_touch_grid_step_sequencer.sv
